/* src/crps_pkg.sv */
// shared types, constants and codes for the catmull-rom path smoother
`timescale 1ns / 1ps
`default_nettype none

package crps_pkg;

    localparam int          MAX_SPS     = 31;
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [16:0] TENSION_RST = 17'd32768;
    localparam logic [4:0]  SPS_RST     = 5'd8;

    // configuration register indexes
    localparam logic CFG_TENSION = 1'b0;
    localparam logic CFG_SPS     = 1'b1;

    // serial divider sizes
    localparam int POLY_DW = 54;
    localparam int POLY_VW = 15;
    localparam int LIN_DW  = 40;
    localparam int PRS_DW  = 24;
    localparam int N_VW    = 5;

    typedef struct packed {
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic        [16:0] pressure_in;
        logic signed [15:0] tilt_x_in;
        logic signed [15:0] tilt_y_in;
        logic        [2:0]  space_in;
        logic               path_last;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic        [16:0] pressure_out;
        logic signed [15:0] tilt_x_out;
        logic signed [15:0] tilt_y_out;
        logic        [2:0]  space_out;
        logic               run_last;
    } t_out_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EMIT_W2,
        ST_EMIT_CUR,
        ST_SEG_SETUP,
        ST_A,
        ST_B,
        ST_C,
        ST_D,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_F,
        ST_OUT,
        ST_COMMIT
    } t_state;

    typedef enum logic [1:0] {
        SRC_SMP,
        SRC_W2,
        SRC_CUR
    } t_out_src;

    typedef struct packed {
        logic       load_in;
        logic       seg_setup;
        logic       seg_late;
        logic       p0_old;
        logic       stage_a;
        logic       stage_b;
        logic       stage_c;
        logic       stage_d;
        logic       div_start;
        logic       stage_f;
        logic       out_load;
        t_out_src   out_src;
        logic       out_last;
        logic       commit;
        logic [4:0] s;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* src/crps_div.sv */
// serial signed floor divider by a positive divisor, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module crps_div #(
    parameter int DW = 54,
    parameter int VW = 15
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [DW-1:0] i_dividend,
    input  wire logic        [VW-1:0] i_divisor,
    output logic                      o_done,
    output logic signed [DW-1:0]      o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_m;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_d;
    logic          r_neg;

    logic [DW:0]   mag_w;
    logic [VW:0]   rem_sh;
    logic          ge;
    logic [VW:0]   rem_sub;
    logic [VW-1:0] rem_nx;

    // negative dividend: floor(n/d) = -ceil(|n|/d)
    always_comb begin
        if (i_dividend[DW-1]) begin
            mag_w = -{i_dividend[DW-1], i_dividend} + {{(DW+1-VW){1'b0}}, i_divisor}
                    - {{DW{1'b0}}, 1'b1};
        end else begin
            mag_w = {1'b0, i_dividend};
        end
    end

    assign rem_sh  = {r_rem, r_m[DW-1]};
    assign ge      = rem_sh >= {1'b0, r_d};
    assign rem_sub = rem_sh - {1'b0, r_d};
    assign rem_nx  = ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m   <= mag_w[DW-1:0];
            r_rem <= '0;
            r_d   <= i_divisor;
            r_neg <= i_dividend[DW-1];
        end else if (r_busy) begin
            r_rem <= rem_nx;
            r_m   <= {r_m[DW-2:0], ge};
        end
    end

    assign o_done = !r_busy;
    assign o_quot = r_neg ? $signed(-r_m) : $signed(r_m);

endmodule

`default_nettype wire

/* src/crps_ctrl.sv */
// controller state machine: window bookkeeping, segment and sample sequencing
`timescale 1ns / 1ps
`default_nettype none

module crps_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_path_last,
    input  wire logic [4:0]     i_n_eff,
    input  wire crps_pkg::t_sts i_sts,
    output logic                o_in_ready,
    output crps_pkg::t_cmd      o_cmd
);

    crps_pkg::t_state r_state, n_state;
    logic [1:0]       r_seen, n_seen;
    logic             r_last, n_last;
    logic             r_seg, n_seg;
    logic [4:0]       r_s, n_s;
    logic [4:0]       n_m1;
    logic             s_end;

    assign n_m1  = i_n_eff - 5'd1;
    assign s_end = r_s == n_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crps_pkg::ST_IDLE;
            r_seen  <= 2'd0;
            r_last  <= 1'b0;
            r_seg   <= 1'b0;
            r_s     <= 5'd0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
            r_last  <= n_last;
            r_seg   <= n_seg;
            r_s     <= n_s;
        end
    end

    always_comb begin
        n_state = r_state;
        n_seen  = r_seen;
        n_last  = r_last;
        n_seg   = r_seg;
        n_s     = r_s;
        case (r_state)
            crps_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = crps_pkg::ST_DISPATCH;
                    n_last  = i_path_last;
                end
            end
            crps_pkg::ST_DISPATCH: begin
                if (i_n_eff < 5'd2) begin
                    n_state = crps_pkg::ST_EMIT_CUR;
                end else if (r_seen < 2'd2) begin
                    if (!r_last) begin
                        n_state = crps_pkg::ST_COMMIT;
                    end else if (r_seen == 2'd1) begin
                        n_state = crps_pkg::ST_EMIT_W2;
                    end else begin
                        n_state = crps_pkg::ST_EMIT_CUR;
                    end
                end else begin
                    n_seg   = 1'b0;
                    n_state = crps_pkg::ST_SEG_SETUP;
                end
            end
            crps_pkg::ST_EMIT_W2: begin
                if (i_sts.out_free) begin
                    n_state = crps_pkg::ST_EMIT_CUR;
                end
            end
            crps_pkg::ST_EMIT_CUR: begin
                if (i_sts.out_free) begin
                    n_state = crps_pkg::ST_COMMIT;
                end
            end
            crps_pkg::ST_SEG_SETUP: begin
                n_s     = 5'd0;
                n_state = crps_pkg::ST_A;
            end
            crps_pkg::ST_A:         n_state = crps_pkg::ST_B;
            crps_pkg::ST_B:         n_state = crps_pkg::ST_C;
            crps_pkg::ST_C:         n_state = crps_pkg::ST_D;
            crps_pkg::ST_D:         n_state = crps_pkg::ST_DIV_START;
            crps_pkg::ST_DIV_START: n_state = crps_pkg::ST_DIV_WAIT;
            crps_pkg::ST_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = crps_pkg::ST_F;
                end
            end
            crps_pkg::ST_F:         n_state = crps_pkg::ST_OUT;
            crps_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    if (!s_end) begin
                        n_s     = r_s + 5'd1;
                        n_state = crps_pkg::ST_A;
                    end else if (r_last && !r_seg) begin
                        n_seg   = 1'b1;
                        n_state = crps_pkg::ST_SEG_SETUP;
                    end else if (r_last) begin
                        n_state = crps_pkg::ST_EMIT_CUR;
                    end else begin
                        n_state = crps_pkg::ST_COMMIT;
                    end
                end
            end
            crps_pkg::ST_COMMIT: begin
                if (r_last) begin
                    n_seen = 2'd0;
                end else if (r_seen != 2'd3) begin
                    n_seen = r_seen + 2'd1;
                end
                n_state = crps_pkg::ST_IDLE;
            end
            default: n_state = crps_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.out_src  = crps_pkg::SRC_SMP;
        o_cmd.seg_late = r_seg;
        o_cmd.p0_old   = r_seen == 2'd3;
        o_cmd.s        = r_s;
        o_in_ready     = 1'b0;
        case (r_state)
            crps_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            crps_pkg::ST_EMIT_W2: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_src  = crps_pkg::SRC_W2;
            end
            crps_pkg::ST_EMIT_CUR: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_src  = crps_pkg::SRC_CUR;
                o_cmd.out_last = 1'b1;
            end
            crps_pkg::ST_SEG_SETUP: o_cmd.seg_setup = 1'b1;
            crps_pkg::ST_A:         o_cmd.stage_a   = 1'b1;
            crps_pkg::ST_B:         o_cmd.stage_b   = 1'b1;
            crps_pkg::ST_C:         o_cmd.stage_c   = 1'b1;
            crps_pkg::ST_D:         o_cmd.stage_d   = 1'b1;
            crps_pkg::ST_DIV_START: o_cmd.div_start = 1'b1;
            crps_pkg::ST_F:         o_cmd.stage_f   = 1'b1;
            crps_pkg::ST_OUT: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_last = s_end && !r_last;
            end
            crps_pkg::ST_COMMIT:    o_cmd.commit    = 1'b1;
            default: begin
                o_cmd.out_src = crps_pkg::SRC_SMP;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/crps_dp.sv */
// datapath: point window, segment coefficients, sample arithmetic, output register
`timescale 1ns / 1ps
`default_nettype none

module crps_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire crps_pkg::t_cmd    i_cmd,
    input  wire crps_pkg::t_in_req i_in_data,
    input  wire logic [16:0]       i_a_eff,
    input  wire logic [4:0]        i_n_eff,
    input  wire logic              i_out_ready,
    output crps_pkg::t_sts         o_sts,
    output logic                   o_out_valid,
    output crps_pkg::t_out_req     o_out_data
);

    crps_pkg::t_in_req r_pt [4];
    crps_pkg::t_in_req q0, q1, q2, q3;

    logic signed [35:0] e0 [2];
    logic signed [35:0] e1 [2];
    logic signed [35:0] e2 [2];
    logic signed [35:0] e3 [2];
    logic signed [35:0] dv_w [2];

    // segment registers
    logic signed [31:0] r_v1 [2];
    logic signed [35:0] r_d1 [2];
    logic signed [35:0] r_d2 [2];
    logic signed [35:0] r_d3 [2];
    logic signed [32:0] r_dv [2];
    logic        [16:0] r_p1;
    logic signed [17:0] r_dp;
    logic signed [15:0] r_tx;
    logic signed [15:0] r_ty;
    logic        [2:0]  r_sp;
    logic        [16:0] r_a;
    logic        [16:0] r_na;
    logic        [4:0]  r_n;
    logic        [9:0]  r_nn;

    // per-sample pipeline registers
    logic        [14:0] r_nnn;
    logic        [9:0]  r_s2;
    logic        [14:0] r_k1;
    logic        [14:0] r_k2;
    logic        [14:0] r_k3;
    logic signed [37:0] r_ls [2];
    logic signed [23:0] r_dps;
    logic signed [55:0] r_ln [2];
    logic signed [51:0] r_t1 [2];
    logic signed [51:0] r_t2 [2];
    logic signed [51:0] r_t3 [2];
    logic signed [39:0] r_lt [2];
    logic signed [53:0] r_r  [2];
    logic signed [23:0] r_pd;
    logic signed [55:0] r_sx [2];

    logic signed [55:0] ln_rnd [2];
    logic signed [55:0] sx_rnd [2];
    logic signed [41:0] tot [2];
    logic signed [31:0] sat_v [2];

    logic signed [crps_pkg::POLY_DW-1:0] poly_q [2];
    logic signed [crps_pkg::LIN_DW-1:0]  lin_q  [2];
    logic signed [crps_pkg::PRS_DW-1:0]  prs_q;
    logic        [1:0]                   poly_done;
    logic        [1:0]                   lin_done;
    logic                                prs_done;

    logic               r_out_valid;
    crps_pkg::t_out_req r_out;
    crps_pkg::t_out_req out_nx;
    logic signed [5:0]  s_sg;

    assign s_sg = $signed({1'b0, i_cmd.s});

    always_comb begin
        if (i_cmd.seg_late) begin
            q0 = r_pt[1];
            q1 = r_pt[2];
            q2 = r_pt[3];
        end else begin
            q0 = i_cmd.p0_old ? r_pt[0] : r_pt[1];
            q1 = r_pt[1];
            q2 = r_pt[2];
        end
        q3 = r_pt[3];
    end

    always_comb begin
        e0[0] = {{4{q0.x_in[31]}}, q0.x_in};
        e1[0] = {{4{q1.x_in[31]}}, q1.x_in};
        e2[0] = {{4{q2.x_in[31]}}, q2.x_in};
        e3[0] = {{4{q3.x_in[31]}}, q3.x_in};
        e0[1] = {{4{q0.y_in[31]}}, q0.y_in};
        e1[1] = {{4{q1.y_in[31]}}, q1.y_in};
        e2[1] = {{4{q2.y_in[31]}}, q2.y_in};
        e3[1] = {{4{q3.y_in[31]}}, q3.y_in};
        for (int k = 0; k < 2; k++) begin
            dv_w[k] = e2[k] - e1[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pt[3] <= i_in_data;
        end
        if (i_cmd.commit) begin
            r_pt[0] <= r_pt[1];
            r_pt[1] <= r_pt[2];
            r_pt[2] <= r_pt[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seg_setup) begin
            for (int k = 0; k < 2; k++) begin
                r_v1[k] <= e1[k][31:0];
                r_d1[k] <= e2[k] - e0[k];
                r_d2[k] <= (e0[k] <<< 1) - (e1[k] <<< 2) - e1[k] + (e2[k] <<< 2) - e3[k];
                r_d3[k] <= (e1[k] <<< 1) + e1[k] - (e2[k] <<< 1) - e2[k] + e3[k] - e0[k];
                r_dv[k] <= dv_w[k][32:0];
            end
            r_p1 <= q1.pressure_in;
            r_dp <= $signed({1'b0, q2.pressure_in}) - $signed({1'b0, q1.pressure_in});
            r_tx <= q1.tilt_x_in;
            r_ty <= q1.tilt_y_in;
            r_sp <= q1.space_in;
            r_a  <= i_a_eff;
            r_na <= crps_pkg::ONE_Q16 - i_a_eff;
            r_n  <= i_n_eff;
            r_nn <= 10'(i_n_eff) * 10'(i_n_eff);
        end
        if (i_cmd.stage_a) begin
            r_nnn <= 15'(r_nn) * 15'(r_n);
            r_s2  <= 10'(i_cmd.s) * 10'(i_cmd.s);
            r_k1  <= 15'(r_nn) * 15'(i_cmd.s);
            for (int k = 0; k < 2; k++) begin
                r_ls[k] <= 38'(r_dv[k]) * 38'(s_sg);
            end
            r_dps <= 24'(r_dp) * 24'(s_sg);
        end
        if (i_cmd.stage_b) begin
            r_k2 <= 15'(r_s2) * 15'(r_n);
            r_k3 <= 15'(r_s2) * 15'(i_cmd.s);
            for (int k = 0; k < 2; k++) begin
                r_ln[k] <= 56'(r_ls[k]) * 56'($signed({1'b0, r_na}));
            end
        end
        if (i_cmd.stage_c) begin
            for (int k = 0; k < 2; k++) begin
                r_t1[k] <= 52'(r_d1[k]) * 52'($signed({1'b0, r_k1}));
                r_t2[k] <= 52'(r_d2[k]) * 52'($signed({1'b0, r_k2}));
                r_t3[k] <= 52'(r_d3[k]) * 52'($signed({1'b0, r_k3}));
                r_lt[k] <= ln_rnd[k][55:16];
            end
        end
        if (i_cmd.stage_d) begin
            for (int k = 0; k < 2; k++) begin
                r_r[k] <= 54'(r_t1[k]) + 54'(r_t2[k]) + 54'(r_t3[k])
                          + 54'($signed({1'b0, r_nnn[14:1]}));
            end
            r_pd <= r_dps + 24'($signed({1'b0, r_n[4:1]}));
        end
        if (i_cmd.stage_f) begin
            for (int k = 0; k < 2; k++) begin
                r_sx[k] <= 56'($signed({1'b0, r_a})) * 56'($signed(poly_q[k][37:0]));
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            ln_rnd[k] = r_ln[k] + 56'($signed({1'b0, r_n, 15'd0}));
            sx_rnd[k] = r_sx[k] + 56'($signed({1'b0, 17'd65536}));
            tot[k]    = 42'(r_v1[k]) + 42'($signed(sx_rnd[k][55:17])) + 42'(lin_q[k]);
            if (tot[k] > 42'sd2147483647) begin
                sat_v[k] = 32'sh7fffffff;
            end else if (tot[k] < -42'sd2147483648) begin
                sat_v[k] = 32'sh80000000;
            end else begin
                sat_v[k] = tot[k][31:0];
            end
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_coord
        crps_div #(
            .DW (crps_pkg::POLY_DW),
            .VW (crps_pkg::POLY_VW)
        ) u_poly_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (i_cmd.div_start),
            .i_dividend (r_r[g]),
            .i_divisor  (r_nnn),
            .o_done     (poly_done[g]),
            .o_quot     (poly_q[g])
        );

        crps_div #(
            .DW (crps_pkg::LIN_DW),
            .VW (crps_pkg::N_VW)
        ) u_lin_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (i_cmd.div_start),
            .i_dividend (r_lt[g]),
            .i_divisor  (r_n),
            .o_done     (lin_done[g]),
            .o_quot     (lin_q[g])
        );
    end

    crps_div #(
        .DW (crps_pkg::PRS_DW),
        .VW (crps_pkg::N_VW)
    ) u_prs_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_pd),
        .i_divisor  (r_n),
        .o_done     (prs_done),
        .o_quot     (prs_q)
    );

    always_comb begin
        case (i_cmd.out_src)
            crps_pkg::SRC_W2: begin
                out_nx.x_out        = r_pt[2].x_in;
                out_nx.y_out        = r_pt[2].y_in;
                out_nx.pressure_out = r_pt[2].pressure_in;
                out_nx.tilt_x_out   = r_pt[2].tilt_x_in;
                out_nx.tilt_y_out   = r_pt[2].tilt_y_in;
                out_nx.space_out    = r_pt[2].space_in;
            end
            crps_pkg::SRC_CUR: begin
                out_nx.x_out        = r_pt[3].x_in;
                out_nx.y_out        = r_pt[3].y_in;
                out_nx.pressure_out = r_pt[3].pressure_in;
                out_nx.tilt_x_out   = r_pt[3].tilt_x_in;
                out_nx.tilt_y_out   = r_pt[3].tilt_y_in;
                out_nx.space_out    = r_pt[3].space_in;
            end
            default: begin
                out_nx.x_out        = sat_v[0];
                out_nx.y_out        = sat_v[1];
                out_nx.pressure_out = r_p1 + prs_q[16:0];
                out_nx.tilt_x_out   = r_tx;
                out_nx.tilt_y_out   = r_ty;
                out_nx.space_out    = r_sp;
            end
        endcase
        out_nx.run_last = i_cmd.out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= out_nx;
        end
    end

    assign o_sts.div_done = (&poly_done) && (&lin_done) && prs_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

`default_nettype wire

/* src/catmull_rom_path_smoother.sv */
// top level of the catmull-rom path smoother: configuration registers and instances
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_in_data  (t_in_req)
//  output    out        o_out_valid / i_out_ready  o_out_data (t_out_req)
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  each smoothed sample waits on the 54-step serial divider behind the cubic term;
//  a point emitted unchanged skips the divider; each request also passes dispatch and
//  commit, and each segment passes coefficient setup
//  a request is taken only while the controller is idle; one result register holds
//  the last sample while the next one is computed, and stalls the sequence when full
//  synchronous active-low reset clears control state and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module catmull_rom_path_smoother #(
    parameter int MAX_SPS = crps_pkg::MAX_SPS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire crps_pkg::t_in_req  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output crps_pkg::t_out_req      o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [16:0]        i_cfg_data
);

    logic [16:0]    r_tension;
    logic [4:0]     r_sps;
    logic [16:0]    a_eff;
    logic [4:0]     n_eff;
    crps_pkg::t_cmd cmd;
    crps_pkg::t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension <= crps_pkg::TENSION_RST;
            r_sps     <= crps_pkg::SPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                crps_pkg::CFG_TENSION: r_tension <= i_cfg_data;
                crps_pkg::CFG_SPS:     r_sps     <= i_cfg_data[4:0];
                default:               r_sps     <= r_sps;
            endcase
        end
    end

    assign a_eff = (r_tension > crps_pkg::ONE_Q16) ? crps_pkg::ONE_Q16 : r_tension;
    assign n_eff = (r_sps > 5'(MAX_SPS)) ? 5'(MAX_SPS) : r_sps;

    crps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_path_last (i_in_data.path_last),
        .i_n_eff     (n_eff),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    crps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_a_eff     (a_eff),
        .i_n_eff     (n_eff),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
